// File: src/odh_pkg.sv
// shared types, mode codes and threshold tables for the ordered dither halftoner
package odh_pkg;

    localparam int PIX_W   = 8;
    localparam int MODE_W  = 2;
    localparam int PHASE_W = 2;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [PHASE_W-1:0] phase_t;

    localparam mode_t MODE_FIXED  = 2'd0;
    localparam mode_t MODE_BAYER2 = 2'd1;
    localparam mode_t MODE_BAYER4 = 2'd2;
    localparam mode_t MODE_LEVEL4 = 2'd3;

    localparam pix_t FIXED_THR = 8'd127;
    localparam pix_t LVL_ZERO  = 8'd0;
    localparam pix_t LVL_ONE   = 8'd63;
    localparam pix_t LVL_TWO   = 8'd127;
    localparam pix_t LVL_THREE = 8'd191;
    localparam pix_t LVL_FULL  = 8'd255;

    typedef struct packed {
        pix_t pixel;
        logic frame_start;
        logic row_end;
    } in_beat_t;

    typedef struct packed {
        pix_t out_pixel;
        logic out_row_end;
    } out_beat_t;

    // 2x2 matrix, index {row, col}
    function automatic pix_t bayer2_thr(input logic [1:0] idx);
        pix_t thr;
        unique case (idx)
            2'd0: thr = 8'd96;
            2'd1: thr = 8'd160;
            2'd2: thr = 8'd224;
            2'd3: thr = 8'd32;
            default: thr = 8'd96;
        endcase
        return thr;
    endfunction

    // 4x4 matrix, index {row, col}
    function automatic pix_t bayer4_thr(input logic [3:0] idx);
        pix_t thr;
        unique case (idx)
            4'd0:  thr = 8'd88;
            4'd1:  thr = 8'd151;
            4'd2:  thr = 8'd104;
            4'd3:  thr = 8'd167;
            4'd4:  thr = 8'd215;
            4'd5:  thr = 8'd24;
            4'd6:  thr = 8'd231;
            4'd7:  thr = 8'd40;
            4'd8:  thr = 8'd120;
            4'd9:  thr = 8'd183;
            4'd10: thr = 8'd72;
            4'd11: thr = 8'd135;
            4'd12: thr = 8'd247;
            4'd13: thr = 8'd56;
            4'd14: thr = 8'd199;
            4'd15: thr = 8'd8;
            default: thr = 8'd88;
        endcase
        return thr;
    endfunction

    // four-level thresholds, lowest step
    function automatic pix_t level_a_thr(input logic [1:0] idx);
        pix_t thr;
        unique case (idx)
            2'd0: thr = 8'd21;
            2'd1: thr = 8'd42;
            2'd2: thr = 8'd64;
            2'd3: thr = 8'd0;
            default: thr = 8'd21;
        endcase
        return thr;
    endfunction

    function automatic pix_t level_b_thr(input logic [1:0] idx);
        pix_t thr;
        unique case (idx)
            2'd0: thr = 8'd106;
            2'd1: thr = 8'd128;
            2'd2: thr = 8'd150;
            2'd3: thr = 8'd85;
            default: thr = 8'd106;
        endcase
        return thr;
    endfunction

    function automatic pix_t level_c_thr(input logic [1:0] idx);
        pix_t thr;
        unique case (idx)
            2'd0: thr = 8'd192;
            2'd1: thr = 8'd213;
            2'd2: thr = 8'd234;
            2'd3: thr = 8'd171;
            default: thr = 8'd192;
        endcase
        return thr;
    endfunction

endpackage

// File: src/odh_quantize.sv
// per-pixel threshold lookup and level selection
module odh_quantize (
    input  odh_pkg::mode_t  mode,
    input  odh_pkg::phase_t row_phase,
    input  odh_pkg::phase_t col_phase,
    input  odh_pkg::pix_t   pixel,
    output odh_pkg::pix_t   level
);
    import odh_pkg::*;

    logic [1:0] idx2;
    logic [3:0] idx4;
    pix_t       thr2;
    pix_t       thr4;
    pix_t       thr_a;
    pix_t       thr_b;
    pix_t       thr_c;

    assign idx2  = {row_phase[0], col_phase[0]};
    assign idx4  = {row_phase, col_phase};
    assign thr2  = bayer2_thr(idx2);
    assign thr4  = bayer4_thr(idx4);
    assign thr_a = level_a_thr(idx2);
    assign thr_b = level_b_thr(idx2);
    assign thr_c = level_c_thr(idx2);

    always_comb
    begin
        unique case (mode)
            MODE_FIXED:  level = (pixel < FIXED_THR) ? LVL_ZERO : LVL_FULL;
            MODE_BAYER2: level = (pixel < thr2) ? LVL_ZERO : LVL_FULL;
            MODE_BAYER4: level = (pixel < thr4) ? LVL_ZERO : LVL_FULL;
            MODE_LEVEL4:
            begin
                priority if (pixel < thr_a)
                    level = LVL_ZERO;
                else if (pixel < thr_b)
                    level = LVL_ONE;
                else if (pixel < thr_c)
                    level = LVL_TWO;
                else
                    level = LVL_THREE;
            end
            default: level = LVL_ZERO;
        endcase
    end

endmodule

// File: src/ordered_dither_halftoner_core.sv
// top level of the ordered dither halftoner
// path: an accepted beat passes the input register, then the result register
// throughput: one pixel per cycle while results are taken; input and result registers
//   form a two-stage pipeline, advancing when the result one is empty or being taken
// reset: asynchronous active-low rst_n clears both valid flags, the mode register
//   (fixed threshold) and the row and column phases; payload registers are not reset
module ordered_dither_halftoner_core (
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port, mode register only
    input  logic              cfg_we,
    input  odh_pkg::mode_t    cfg_wdata,
    // pixel input channel
    input  logic              pix_valid,
    output logic              pix_ready,
    input  odh_pkg::in_beat_t pix_data,
    // halftoned result channel
    output logic               res_valid,
    input  logic               res_ready,
    output odh_pkg::out_beat_t res_data
);
    import odh_pkg::*;

    // configuration
    mode_t mode_reg;

    // raster position of the next pixel to arrive
    phase_t row_phase_reg;
    phase_t col_phase_reg;
    phase_t row_phase_next;
    phase_t col_phase_next;

    // phases that the current input beat is halftoned with
    phase_t row_use;
    phase_t col_use;

    // input stage: pixel plus its resolved phase
    logic   s1_valid_reg;
    pix_t   s1_pixel_reg;
    logic   s1_row_end_reg;
    phase_t s1_row_reg;
    phase_t s1_col_reg;

    // result stage
    logic      out_valid_reg;
    out_beat_t out_beat_reg;

    logic in_fire;
    logic s1_advance;
    logic out_free;
    pix_t level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_FIXED;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    // the result register frees when empty or when its beat is taken this cycle
    assign out_free   = !out_valid_reg || res_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign pix_ready  = !s1_valid_reg || out_free;
    assign in_fire    = pix_valid && pix_ready;

    // frame start forces phase (0,0) for this pixel
    always_comb
    begin
        if (pix_data.frame_start)
        begin
            row_use = '0;
            col_use = '0;
        end
        else
        begin
            row_use = row_phase_reg;
            col_use = col_phase_reg;
        end
    end

    // after a row end the column restarts and the row steps; both wrap mod 4
    always_comb
    begin
        if (pix_data.row_end)
        begin
            row_phase_next = row_use + phase_t'(1);
            col_phase_next = '0;
        end
        else
        begin
            row_phase_next = row_use;
            col_phase_next = col_use + phase_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_phase_reg <= '0;
            col_phase_reg <= '0;
        end
        else if (in_fire)
        begin
            row_phase_reg <= row_phase_next;
            col_phase_reg <= col_phase_next;
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pix_ready)
            s1_valid_reg <= pix_valid;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg   <= pix_data.pixel;
            s1_row_end_reg <= pix_data.row_end;
            s1_row_reg     <= row_use;
            s1_col_reg     <= col_use;
        end
    end

    odh_quantize u_quantize (
        .mode      (mode_reg),
        .row_phase (s1_row_reg),
        .col_phase (s1_col_reg),
        .pixel     (s1_pixel_reg),
        .level     (level)
    );

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_beat_reg.out_pixel   <= level;
            out_beat_reg.out_row_end <= s1_row_end_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_beat_reg;

endmodule

// File: test/ordered_dither_halftoner_core_test.sv
// self-checking testbench for the ordered dither halftoner core
`timescale 1ns / 1ps

module ordered_dither_halftoner_core_test;

    import odh_pkg::*;

    // cycles with no beat on either side before the run is declared hung
    localparam int STALL_LIMIT  = 2000;
    // settle time after the last result, a few times the core latency
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 8;
    localparam int PLAN_ROWS    = 25;
    // random items in this index window run with no idling on either side
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 799;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    mode_t     cfg_wdata = MODE_FIXED;
    logic      pix_valid = 1'b0;
    logic      pix_ready;
    in_beat_t  pix_data = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    out_beat_t res_data;

    ordered_dither_halftoner_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // threshold matrices, indexed [row phase][column phase]
    pix_t bayer2_grid [2][2] = '{'{8'd96, 8'd160}, '{8'd224, 8'd32}};
    pix_t bayer4_grid [4][4] = '{
        '{8'd88,  8'd151, 8'd104, 8'd167},
        '{8'd215, 8'd24,  8'd231, 8'd40},
        '{8'd120, 8'd183, 8'd72,  8'd135},
        '{8'd247, 8'd56,  8'd199, 8'd8}
    };
    // four-level steps: below step a gives zero, below b one, below c two, else three
    pix_t step_a_grid [2][2] = '{'{8'd21, 8'd42}, '{8'd64, 8'd0}};
    pix_t step_b_grid [2][2] = '{'{8'd106, 8'd128}, '{8'd150, 8'd85}};
    pix_t step_c_grid [2][2] = '{'{8'd192, 8'd213}, '{8'd234, 8'd171}};

    // shadow of the block state as seen by the predictor
    mode_t  shadow_mode = MODE_FIXED;
    phase_t shadow_col = '0;
    phase_t shadow_row = '0;

    out_beat_t expected_halftones [$];
    int        mismatches = 0;
    int        pixels_sent = 0;
    int        halftones_seen = 0;
    int        frames_started = 0;
    bit [3:0]  modes_visited = '0;
    bit        calm = 1'b0;
    int        quiet_cycles = 0;

    // directed stimulus; want is used only where typed is set
    typedef struct {
        mode_t mode;
        pix_t  pixel;
        bit    fs;
        bit    re;
        bit    typed;
        pix_t  want;
    } plan_row_t;

    plan_row_t plan [PLAN_ROWS] = '{
        // reset mode: fixed threshold, extremes and both sides of the threshold
        '{MODE_FIXED,  8'd0,   1'b1, 1'b0, 1'b1, LVL_ZERO},
        '{MODE_FIXED,  8'd255, 1'b0, 1'b0, 1'b1, LVL_FULL},
        '{MODE_FIXED,  8'd127, 1'b0, 1'b0, 1'b1, LVL_FULL},
        '{MODE_FIXED,  8'd126, 1'b0, 1'b1, 1'b1, LVL_ZERO},
        // 2x2 matrix, with a pixel that both starts a frame and ends a row
        '{MODE_BAYER2, 8'd255, 1'b1, 1'b0, 1'b1, LVL_FULL},
        '{MODE_BAYER2, 8'd0,   1'b0, 1'b0, 1'b1, LVL_ZERO},
        '{MODE_BAYER2, 8'd96,  1'b1, 1'b1, 1'b0, LVL_ZERO},
        '{MODE_BAYER2, 8'd223, 1'b0, 1'b0, 1'b0, LVL_ZERO},
        '{MODE_BAYER2, 8'd32,  1'b0, 1'b0, 1'b0, LVL_ZERO},
        // 4x4 matrix: a row longer than four, then rows past the fourth
        '{MODE_BAYER4, 8'd255, 1'b1, 1'b0, 1'b1, LVL_FULL},
        '{MODE_BAYER4, 8'd150, 1'b0, 1'b0, 1'b0, LVL_ZERO},
        '{MODE_BAYER4, 8'd103, 1'b0, 1'b0, 1'b0, LVL_ZERO},
        '{MODE_BAYER4, 8'd167, 1'b0, 1'b0, 1'b0, LVL_ZERO},
        '{MODE_BAYER4, 8'd87,  1'b0, 1'b0, 1'b0, LVL_ZERO},
        '{MODE_BAYER4, 8'd151, 1'b0, 1'b1, 1'b0, LVL_ZERO},
        '{MODE_BAYER4, 8'd214, 1'b0, 1'b1, 1'b0, LVL_ZERO},
        '{MODE_BAYER4, 8'd120, 1'b0, 1'b1, 1'b0, LVL_ZERO},
        '{MODE_BAYER4, 8'd8,   1'b0, 1'b1, 1'b0, LVL_ZERO},
        '{MODE_BAYER4, 8'd87,  1'b0, 1'b1, 1'b0, LVL_ZERO},
        '{MODE_BAYER4, 8'd0,   1'b0, 1'b0, 1'b1, LVL_ZERO},
        // four levels, with a frame restart on the pixel right after a row end
        '{MODE_LEVEL4, 8'd0,   1'b1, 1'b0, 1'b1, LVL_ZERO},
        '{MODE_LEVEL4, 8'd255, 1'b0, 1'b0, 1'b1, LVL_THREE},
        '{MODE_LEVEL4, 8'd42,  1'b0, 1'b0, 1'b0, LVL_ZERO},
        '{MODE_LEVEL4, 8'd63,  1'b0, 1'b1, 1'b0, LVL_ZERO},
        '{MODE_LEVEL4, 8'd171, 1'b1, 1'b0, 1'b0, LVL_ZERO}
    };

    // mode for each random phase, extremes first
    mode_t phase_modes [NUM_PHASES] = '{
        MODE_LEVEL4, MODE_FIXED, MODE_BAYER4, MODE_BAYER2,
        MODE_FIXED, MODE_LEVEL4, MODE_BAYER2, MODE_BAYER4
    };

    initial
    begin
        forever #1 clk = ~clk;
    end

    // halftone one pixel against the shadow state and advance the phases
    function automatic out_beat_t halftone_pixel(in_beat_t b);
        out_beat_t o;
        phase_t    r;
        phase_t    c;
        if (b.frame_start)
        begin
            shadow_col = '0;
            shadow_row = '0;
        end
        r = shadow_row;
        c = shadow_col;
        o.out_row_end = b.row_end;
        case (shadow_mode)
            MODE_FIXED:
                o.out_pixel = (b.pixel < FIXED_THR) ? LVL_ZERO : LVL_FULL;
            MODE_BAYER2:
                o.out_pixel = (b.pixel < bayer2_grid[r[0]][c[0]]) ? LVL_ZERO : LVL_FULL;
            MODE_BAYER4:
                o.out_pixel = (b.pixel < bayer4_grid[r][c]) ? LVL_ZERO : LVL_FULL;
            default:
            begin
                if (b.pixel < step_a_grid[r[0]][c[0]])
                    o.out_pixel = LVL_ZERO;
                else if (b.pixel < step_b_grid[r[0]][c[0]])
                    o.out_pixel = LVL_ONE;
                else if (b.pixel < step_c_grid[r[0]][c[0]])
                    o.out_pixel = LVL_TWO;
                else
                    o.out_pixel = LVL_THREE;
            end
        endcase
        if (b.row_end)
        begin
            shadow_col = '0;
            shadow_row = shadow_row + 1'b1;
        end
        else
        begin
            shadow_col = shadow_col + 1'b1;
        end
        return o;
    endfunction

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // offer one pixel beat; entered and left at a rising edge
    task automatic send_pixel(in_beat_t b, bit typed, pix_t want);
        out_beat_t predicted;
        // random idle cycles ahead of the beat
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 11)
            begin
                pix_valid <= 1'b0;
                @(posedge clk);
            end
        end
        pix_valid <= 1'b1;
        pix_data  <= b;
        // ready is stable mid-cycle; the beat goes through at the next edge
        do @(negedge clk); while (!pix_ready);
        @(posedge clk);
        predicted = halftone_pixel(b);
        if (typed)
            predicted.out_pixel = want;
        expected_halftones.push_back(predicted);
        pixels_sent++;
        if (b.frame_start)
            frames_started++;
    endtask

    // write the mode register once the pipeline has emptied
    task automatic set_mode(mode_t m);
        pix_valid <= 1'b0;
        do @(negedge clk); while (expected_halftones.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_mode = m;
    endtask

    function automatic pix_t random_pixel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // result side: ready drops at random about 11 percent of the time, never while calm
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
            res_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    // result checker, sampled mid-cycle where outputs are settled
    always @(negedge clk)
    begin
        out_beat_t want;
        if (rst_n && res_valid && res_ready)
        begin
            halftones_seen++;
            if (expected_halftones.size() == 0)
            begin
                note_failure($sformatf("unexpected beat pixel=%0d row_end=%0b",
                                       res_data.out_pixel, res_data.out_row_end));
            end
            else
            begin
                want = expected_halftones.pop_front();
                if (res_data.out_pixel !== want.out_pixel ||
                    res_data.out_row_end !== want.out_row_end)
                    note_failure($sformatf("result %0d: expected pixel=%0d row_end=%0b, got pixel=%0d row_end=%0b",
                                           halftones_seen, want.out_pixel, want.out_row_end,
                                           res_data.out_pixel, res_data.out_row_end));
            end
        end
    end

    // watchdog: ends the run after too long with no beat on either side
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((pix_valid && pix_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_halftones.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        in_beat_t b;
        int       item;
        int       rows_left;
        int       row_len;
        int       col;
        bit       frame_first;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part; the first rows rely on the reset mode
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].mode != shadow_mode)
                set_mode(plan[i].mode);
            modes_visited[shadow_mode] = 1'b1;
            b.pixel       = plan[i].pixel;
            b.frame_start = plan[i].fs;
            b.row_end     = plan[i].re;
            send_pixel(b, plan[i].typed, plan[i].want);
        end

        // random part: mostly well-formed frames, some beats with random marks
        item = 0;
        rows_left = 0;
        row_len = 1;
        col = 0;
        frame_first = 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_mode(phase_modes[ph]);
            modes_visited[shadow_mode] = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                calm = (item >= CALM_FIRST) && (item <= CALM_LAST);
                if (rows_left == 0)
                begin
                    // new frame, rows often longer or taller than the matrix
                    rows_left   = $urandom_range(1, 7);
                    row_len     = $urandom_range(1, 9);
                    col         = 0;
                    frame_first = 1'b1;
                end
                b.pixel = random_pixel();
                if ($urandom_range(0, 99) < 10)
                begin
                    // noise beat: marks at random, frame bookkeeping left alone
                    b.frame_start = 1'($urandom_range(0, 1));
                    b.row_end     = 1'($urandom_range(0, 1));
                end
                else
                begin
                    b.frame_start = frame_first;
                    b.row_end     = (col == row_len - 1);
                    frame_first   = 1'b0;
                    if (b.row_end)
                    begin
                        col = 0;
                        rows_left--;
                    end
                    else
                    begin
                        col++;
                    end
                end
                send_pixel(b, 1'b0, LVL_ZERO);
                item++;
            end
        end
        calm = 1'b0;

        // drain, then give any stray beat time to show up
        pix_valid <= 1'b0;
        do @(negedge clk); while (expected_halftones.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_halftones.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_halftones.size()));

        $display("covered %0d pixels in %0d frames, %0d halftoned beats checked",
                 pixels_sent, frames_started, halftones_seen);
        $display("modes visited mask %4b, %0d mismatches", modes_visited, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
